// ===== design/kpcs_pkg.sv =====
package kpcs_pkg;

    // Width of one packed k-mer word and of a result value.
    localparam int KMER_WIDTH = 64;
    localparam int BASE_WIDTH = 2;
    localparam int LEN_WIDTH = 6;

    // Longest and shortest k-mer the scan works on; other lengths are clamped.
    localparam int MIN_KMER_LEN = 2;
    localparam int MAX_KMER_LEN = 32;

    // Default width of the item index counter.
    localparam int DEFAULT_INDEX_WIDTH = 40;

    // One input word causes at most this many result words.
    localparam int MAX_RESULTS = 3;
    localparam int PUSH_CNT_WIDTH = 2;

    // Result queue depth.
    localparam int QUEUE_DEPTH = 8;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_KMER_LEN = 1'b0;
    localparam logic REG_PASS_MODE = 1'b1;

    // Pass modes.
    localparam logic MODE_OUT_PASS = 1'b0;
    localparam logic MODE_IN_PASS = 1'b1;

    // Result kinds.
    localparam logic KIND_KMER = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // One result word.
    typedef struct packed {
        logic                  kind;
        logic [KMER_WIDTH-1:0] value;
        logic [BASE_WIDTH-1:0] lead_base;
        logic                  last;
    } kpcs_result_t;

    // Result words produced by one accepted input word, compacted from slot 0.
    typedef struct packed {
        logic [PUSH_CNT_WIDTH-1:0]            count;
        kpcs_result_t [MAX_RESULTS-1:0]       item;
    } kpcs_push_t;

endpackage

// ===== design/kpcs_result_queue.sv =====
module kpcs_result_queue
    import kpcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  kpcs_push_t   push,
    output logic         space_ok,
    output logic         m_valid,
    input  logic         m_ready,
    output kpcs_result_t head
);

    localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    kpcs_result_t         mem [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic                 pop;

    // A word leaves when the receiver takes the head entry.
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign space_ok = (count_reg <= CNT_WIDTH'(QUEUE_DEPTH - MAX_RESULTS));

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_WIDTH'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_WIDTH'(pop);
        count_next  = count_reg + CNT_WIDTH'(push.count) - CNT_WIDTH'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: up to three consecutive entries are written in one cycle.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (PUSH_CNT_WIDTH'(i) < push.count) begin
                mem[wr_ptr_reg + PTR_WIDTH'(i)] <= push.item[i];
            end
        end
    end

endmodule

// ===== design/kmer_prefix_collision_scan.sv =====
// Prefix collision scan over a sorted stream of 2-bit-packed k-mers.
//
// Input channel (s_valid, s_ready, s_kmer) takes one packed k-mer per word,
// leading base most significant. Result channel (m_valid, m_ready, m_kind,
// m_value, m_lead_base, m_last) gives colliding k-mers and, in out-pass mode,
// partition start markers that carry the item index. m_last marks the final
// result word caused by one input word; words that cause nothing give none.
// The APB port sets kmer_len (address 0) and pass_mode (address 4); write it
// only while the block is idle.
//
// Each accepted word is evaluated in the cycle it is accepted and its results
// enter an eight-entry result queue; when the queue was empty, the first result
// is offered on the cycle after acceptance. One input word can be taken every
// cycle; s_ready drops only while the queue has fewer than three free entries,
// which happens when the receiver stalls or bursts of collisions outpace one
// result per cycle. Results leave at up to one word per cycle.
//
// Reset (aresetn low, synchronous) empties the queue, clears the scan state
// and the item index, and sets kmer_len to 32 and pass_mode to out pass.
module kmer_prefix_collision_scan
    import kpcs_pkg::*;
#(
    parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KMER_WIDTH-1:0] s_kmer,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [KMER_WIDTH-1:0] m_value,
    output logic [BASE_WIDTH-1:0] m_lead_base,
    output logic                  m_last
);

    localparam int SHIFT_WIDTH = $clog2(KMER_WIDTH);

    // Configuration registers.
    logic [LEN_WIDTH-1:0]   kmer_len_reg;
    logic                   pass_mode_reg;

    // Scan state.
    logic [KMER_WIDTH-1:0]  prev_kmer_reg, prev_kmer_next;
    logic [KMER_WIDTH-1:0]  last_written_reg, last_written_next;
    logic                   written_valid_reg, written_valid_next;
    logic [BASE_WIDTH-1:0]  prev_base_reg;
    logic                   seen_any_reg;
    logic [INDEX_WIDTH-1:0] item_count_reg;

    // Per-word logic.
    logic                   accept;
    logic                   space_ok;
    logic [LEN_WIDTH-1:0]   k_eff;
    logic [SHIFT_WIDTH-1:0] lead_shift;
    logic [KMER_WIDTH-1:0]  len_mask;
    logic [KMER_WIDTH-1:0]  cur;
    logic [BASE_WIDTH-1:0]  base;
    logic [KMER_WIDTH-1:0]  rotated;
    logic [KMER_WIDTH-1:0]  key;
    logic [KMER_WIDTH-1:0]  prev_unrotated;
    logic                   collide;
    logic                   emit_prev, emit_cur, emit_mark;
    kpcs_result_t           res_prev, res_cur, res_mark;
    kpcs_push_t             push;
    kpcs_result_t           head;
    logic                   cfg_write;

    assign accept  = s_valid && s_ready;
    assign s_ready = space_ok;

    // Register write and read access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_KMER_LEN:  prdata = 32'(kmer_len_reg);
            REG_PASS_MODE: prdata = 32'(pass_mode_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_len_reg  <= LEN_WIDTH'(MAX_KMER_LEN);
            pass_mode_reg <= MODE_OUT_PASS;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_KMER_LEN:  kmer_len_reg  <= pwdata[LEN_WIDTH-1:0];
                REG_PASS_MODE: pass_mode_reg <= pwdata[0];
                default:       kmer_len_reg  <= kmer_len_reg;
            endcase
        end
    end

    // Clamp the length and build the mask and the leading base position.
    always_comb begin
        if (kmer_len_reg < LEN_WIDTH'(MIN_KMER_LEN)) begin
            k_eff = LEN_WIDTH'(MIN_KMER_LEN);
        end else if (kmer_len_reg > LEN_WIDTH'(MAX_KMER_LEN)) begin
            k_eff = LEN_WIDTH'(MAX_KMER_LEN);
        end else begin
            k_eff = kmer_len_reg;
        end
        lead_shift = SHIFT_WIDTH'({k_eff - LEN_WIDTH'(1), 1'b0});
        if (k_eff >= LEN_WIDTH'(KMER_WIDTH / BASE_WIDTH)) begin
            len_mask = '1;
        end else begin
            len_mask = ~({KMER_WIDTH{1'b1}} << {k_eff, 1'b0});
        end
    end

    // Mask, leading base and rotations of the incoming word.
    always_comb begin
        cur     = s_kmer & len_mask;
        base    = BASE_WIDTH'(cur >> lead_shift);
        rotated = ((cur << BASE_WIDTH) | KMER_WIDTH'(base)) & len_mask;
        key     = (pass_mode_reg == MODE_IN_PASS) ? rotated : cur;
        prev_unrotated = ((prev_kmer_reg >> BASE_WIDTH)
                         | (KMER_WIDTH'(prev_kmer_reg[BASE_WIDTH-1:0]) << lead_shift))
                         & len_mask;
    end

    // Decide which results this word causes.
    always_comb begin
        collide   = seen_any_reg
                    && ((prev_kmer_reg >> BASE_WIDTH) == (key >> BASE_WIDTH));
        emit_cur  = collide;
        emit_prev = collide && ((pass_mode_reg == MODE_OUT_PASS) || !written_valid_reg
                                || (prev_kmer_reg != last_written_reg));
        emit_mark = (pass_mode_reg == MODE_OUT_PASS) && seen_any_reg
                    && (base != prev_base_reg);
    end

    // Assemble the result words; the unrotated current word equals cur.
    always_comb begin
        res_prev.kind      = KIND_KMER;
        res_prev.value     = (pass_mode_reg == MODE_IN_PASS) ? prev_unrotated
                                                             : prev_kmer_reg;
        res_prev.lead_base = '0;
        res_prev.last      = 1'b0;

        res_cur.kind       = KIND_KMER;
        res_cur.value      = cur;
        res_cur.lead_base  = '0;
        res_cur.last       = 1'b0;

        res_mark.kind      = KIND_MARKER;
        res_mark.value     = KMER_WIDTH'(item_count_reg);
        res_mark.lead_base = base;
        res_mark.last      = 1'b0;

        // The current k-mer is always present when the previous one is, and
        // markers only occur in out pass where both k-mers come as a pair.
        push.count = accept ? (PUSH_CNT_WIDTH'(emit_prev) + PUSH_CNT_WIDTH'(emit_cur)
                               + PUSH_CNT_WIDTH'(emit_mark))
                            : '0;
        push.item[0] = emit_prev ? res_prev : (emit_cur ? res_cur : res_mark);
        push.item[1] = emit_prev ? res_cur : res_mark;
        push.item[2] = res_mark;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            push.item[i].last = (push.count == PUSH_CNT_WIDTH'(i + 1));
        end
    end

    // Next scan state.
    always_comb begin
        prev_kmer_next     = key;
        last_written_next  = last_written_reg;
        written_valid_next = written_valid_reg;
        if ((pass_mode_reg == MODE_IN_PASS) && collide) begin
            last_written_next  = rotated;
            written_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_kmer_reg     <= '0;
            last_written_reg  <= '1;
            written_valid_reg <= 1'b0;
            prev_base_reg     <= '0;
            seen_any_reg      <= 1'b0;
            item_count_reg    <= '0;
        end else if (accept) begin
            prev_kmer_reg     <= prev_kmer_next;
            last_written_reg  <= last_written_next;
            written_valid_reg <= written_valid_next;
            prev_base_reg     <= base;
            seen_any_reg      <= 1'b1;
            item_count_reg    <= item_count_reg + INDEX_WIDTH'(1);
        end
    end

    // Result queue decouples the receiver from the scan.
    kpcs_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_kind      = head.kind;
    assign m_value     = head.value;
    assign m_lead_base = head.lead_base;
    assign m_last      = head.last;

endmodule
